FILE: rtl/swhsr_pkg.sv
package swhsr_pkg;

   // Frame and counter sizes
   localparam int FRAME_BITS        = 40;
   localparam int PULSE_COUNT_WIDTH = 16;
   localparam int LONG_W            = 24;
   localparam int SHORT_W           = 16;
   localparam int BYTE_W            = 8;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_ADDR_W        = 5;

   // Register reset values
   localparam logic [LONG_W-1:0]  RELEASE_RST      = 24'd250000;
   localparam logic [LONG_W-1:0]  START_LOW_RST    = 24'd20000;
   localparam logic [SHORT_W-1:0] START_HIGH_RST   = 16'd40;
   localparam logic [SHORT_W-1:0] SETTLE_RST       = 16'd10;
   localparam logic [LONG_W-1:0]  MIN_INTERVAL_RST = 24'd2000000;
   localparam logic [SHORT_W-1:0] TIMEOUT_RST      = 16'd1000;

   // Register indexes (word address)
   typedef enum logic [2:0] {
      REG_RELEASE      = 3'd0,
      REG_START_LOW    = 3'd1,
      REG_START_HIGH   = 3'd2,
      REG_SETTLE       = 3'd3,
      REG_MIN_INTERVAL = 3'd4,
      REG_TIMEOUT      = 3'd5
   } reg_index_type;

   // Read sequence phases
   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_RELEASE    = 4'd1,
      PH_START_LOW  = 4'd2,
      PH_START_HIGH = 4'd3,
      PH_SETTLE     = 4'd4,
      PH_RESP_LOW   = 4'd5,
      PH_RESP_HIGH  = 4'd6,
      PH_BIT_LOW    = 4'd7,
      PH_BIT_HIGH   = 4'd8
   } phase_type;

endpackage

FILE: rtl/swhsr_req_if.sv
interface swhsr_req_if;
   logic valid;
   logic ready;
   logic line_level;
   logic read_request;

   modport source (output valid, output line_level, output read_request, input ready);
   modport sink   (input valid, input line_level, input read_request, output ready);
endinterface

FILE: rtl/swhsr_rsp_if.sv
interface swhsr_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_enable;
   logic       drive_level;
   logic [7:0] humidity;
   logic [7:0] temperature;
   logic       new_data;
   logic       read_failed;
   logic       busy_res;

   modport source (output valid, output drive_enable, output drive_level,
                   output humidity, output temperature, output new_data,
                   output read_failed, output busy_res, input ready);
   modport sink   (input valid, input drive_enable, input drive_level,
                   input humidity, input temperature, input new_data,
                   input read_failed, input busy_res, output ready);
endinterface

FILE: rtl/single_wire_humidity_sensor_reader.sv
// Single-wire humidity sensor reader. Each request word is one sample tick of the data
// line plus a read-request flag, and each word yields exactly one response word, registered
// on the edge that takes it, so one tick is taken every clock cycle while the response side
// keeps up; the whole per-tick update runs in one combinational pass between the request
// handshake and the response register. A stalled response word holds off the request side,
// and a new word enters on the same edge at which the waiting response word is taken.
// A request starts a read only when idle and at least min_interval_ticks have passed since
// the previous accepted one. The read releases the line, drives it low, then high, releases
// and settles (zero-length steps are skipped), skips the sensor's response pulses, then
// times 40 low/high pairs; a bit is 1 when its high time exceeds its low time. Humidity and
// temperature update only on a good checksum (low 8 bits of the sum of bytes 0..3); a
// checksum mismatch or a pulse longer than pulse_timeout_ticks pulses read_failed.
// Registers sit at byte addresses 0,4,..,20 of the CSR port; write them only while idle.
module single_wire_humidity_sensor_reader #(
   parameter int PULSE_COUNT_WIDTH = swhsr_pkg::PULSE_COUNT_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   swhsr_req_if.sink                        req_chan,
   swhsr_rsp_if.source                      rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [swhsr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [swhsr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [swhsr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import swhsr_pkg::*;

   localparam int                         PCW     = PULSE_COUNT_WIDTH;
   localparam int                         CMP_W   = (PCW > SHORT_W) ? PCW : SHORT_W;
   localparam logic [PCW-1:0]             CNT_MAX = {PCW{1'b1}};
   localparam logic [$clog2(FRAME_BITS+1)-1:0] FRAME_CNT =
      ($clog2(FRAME_BITS+1))'(FRAME_BITS);
   localparam int                         BITS_W  = $clog2(FRAME_BITS+1);

   // Configuration registers
   logic [LONG_W-1:0]  release_ff, start_low_ff, min_interval_ff;
   logic [SHORT_W-1:0] start_high_ff, settle_ff, timeout_ff;

   // Sequencer state
   phase_type          phase_ff, phase_in;
   logic [LONG_W-1:0]  phase_ticks_ff, phase_ticks_in;
   logic [LONG_W-1:0]  since_ff, since_in;
   logic [PCW-1:0]     low_cnt_ff, low_cnt_in;
   logic [PCW-1:0]     high_cnt_ff, high_cnt_in;
   logic [BITS_W-1:0]  bits_ff, bits_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [BYTE_W-1:0]  hum_ff, hum_in, temp_ff, temp_in;

   // Response register
   logic               rsp_valid_ff;
   logic               drive_en_ff, drive_en_in;
   logic               drive_lvl_ff, drive_lvl_in;
   logic               new_data_ff, new_data_in;
   logic               failed_ff, failed_in;
   logic               busy_ff, busy_in;

   logic               take;
   logic               csr_write;
   logic [3:0]         step_nz;
   logic               start_read;
   logic [LONG_W-1:0]  step_len;
   logic [PCW-1:0]     low_bump, high_bump;
   logic               low_tout, high_tout;
   logic [BYTE_W-1:0]  sum8;

   // First nonzero timed step at or after p (response low when none)
   function automatic phase_type first_step(input phase_type p, input logic [3:0] nz);
      phase_type r;
      r = PH_RESP_LOW;
      if (p == PH_RELEASE && nz[0]) begin
         r = PH_RELEASE;
      end else if ((p == PH_RELEASE || p == PH_START_LOW) && nz[1]) begin
         r = PH_START_LOW;
      end else if ((p == PH_RELEASE || p == PH_START_LOW || p == PH_START_HIGH) && nz[2]) begin
         r = PH_START_HIGH;
      end else if (nz[3] && p != PH_RESP_LOW) begin
         r = PH_SETTLE;
      end
      return r;
   endfunction

   assign take       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   assign step_nz = {settle_ff != '0, start_high_ff != '0, start_low_ff != '0,
                     release_ff != '0};

   // Length of the current timed step
   always_comb begin
      case (phase_ff)
         PH_RELEASE:    step_len = release_ff;
         PH_START_LOW:  step_len = start_low_ff;
         PH_START_HIGH: step_len = LONG_W'(start_high_ff);
         default:       step_len = LONG_W'(settle_ff);
      endcase
   end

   // Saturating pulse counts and their timeout checks
   assign low_bump  = (low_cnt_ff != CNT_MAX) ? low_cnt_ff + 1'b1 : CNT_MAX;
   assign high_bump = (high_cnt_ff != CNT_MAX) ? high_cnt_ff + 1'b1 : CNT_MAX;
   assign low_tout  = (CMP_W'(low_bump) > CMP_W'(timeout_ff)) || (low_bump == CNT_MAX);
   assign high_tout = (CMP_W'(high_bump) > CMP_W'(timeout_ff)) || (high_bump == CNT_MAX);

   assign start_read = (phase_ff == PH_IDLE) && req_chan.read_request &&
                       (since_ff >= min_interval_ff);

   // Next state for one tick
   always_comb begin
      phase_in       = phase_ff;
      phase_ticks_in = phase_ticks_ff;
      low_cnt_in     = low_cnt_ff;
      high_cnt_in    = high_cnt_ff;
      bits_in        = bits_ff;
      frame_in       = frame_ff;
      hum_in         = hum_ff;
      temp_in        = temp_ff;
      new_data_in    = 1'b0;
      failed_in      = 1'b0;
      sum8           = '0;

      if (start_read) begin
         since_in = '0;
      end else if (since_ff != {LONG_W{1'b1}}) begin
         since_in = since_ff + 1'b1;
      end else begin
         since_in = since_ff;
      end

      if (start_read) begin
         bits_in        = '0;
         frame_in       = '0;
         low_cnt_in     = '0;
         high_cnt_in    = '0;
         phase_in       = first_step(PH_RELEASE, step_nz);
         phase_ticks_in = '0;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
            end
            PH_RELEASE, PH_START_LOW, PH_START_HIGH, PH_SETTLE: begin
               phase_ticks_in = phase_ticks_ff + 1'b1;
               if (phase_ticks_in >= step_len) begin
                  phase_in       = first_step(phase_type'(phase_ff + 4'd1), step_nz);
                  phase_ticks_in = '0;
                  if (phase_in == PH_RESP_LOW) begin
                     low_cnt_in = '0;
                  end
               end
            end
            PH_RESP_LOW, PH_BIT_LOW: begin
               if (!req_chan.line_level) begin
                  low_cnt_in = low_bump;
                  if (low_tout) begin
                     phase_in  = PH_IDLE;
                     failed_in = 1'b1;
                  end
               end else begin
                  phase_in    = (phase_ff == PH_RESP_LOW) ? PH_RESP_HIGH : PH_BIT_HIGH;
                  high_cnt_in = PCW'(1);
               end
            end
            PH_RESP_HIGH, PH_BIT_HIGH: begin
               if (req_chan.line_level) begin
                  high_cnt_in = high_bump;
                  if (high_tout) begin
                     phase_in  = PH_IDLE;
                     failed_in = 1'b1;
                  end
               end else if (phase_ff == PH_RESP_HIGH) begin
                  phase_in   = PH_BIT_LOW;
                  low_cnt_in = PCW'(1);
               end else begin
                  frame_in = {frame_ff[FRAME_BITS-2:0], high_cnt_ff > low_cnt_ff};
                  bits_in  = bits_ff + 1'b1;
                  if (bits_in >= FRAME_CNT) begin
                     sum8 = frame_in[39:32] + frame_in[31:24] + frame_in[23:16]
                            + frame_in[15:8];
                     if (sum8 == frame_in[7:0]) begin
                        hum_in      = frame_in[39:32];
                        temp_in     = frame_in[23:16];
                        new_data_in = 1'b1;
                     end else begin
                        failed_in = 1'b1;
                     end
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in   = PH_BIT_LOW;
                     low_cnt_in = PCW'(1);
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Line drive and busy from the next phase
   always_comb begin
      drive_en_in  = (phase_in == PH_START_LOW) || (phase_in == PH_START_HIGH);
      drive_lvl_in = (phase_in == PH_START_HIGH);
      busy_in      = (phase_in != PH_IDLE);
   end

   // Advance state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         phase_ticks_ff <= '0;
         since_ff       <= {LONG_W{1'b1}};
         low_cnt_ff     <= '0;
         high_cnt_ff    <= '0;
         bits_ff        <= '0;
         frame_ff       <= '0;
         hum_ff         <= '0;
         temp_ff        <= '0;
      end else if (take) begin
         phase_ff       <= phase_in;
         phase_ticks_ff <= phase_ticks_in;
         since_ff       <= since_in;
         low_cnt_ff     <= low_cnt_in;
         high_cnt_ff    <= high_cnt_in;
         bits_ff        <= bits_in;
         frame_ff       <= frame_in;
         hum_ff         <= hum_in;
         temp_ff        <= temp_in;
      end
   end

   // Hold the response word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         drive_en_ff  <= drive_en_in;
         drive_lvl_ff <= drive_lvl_in;
         new_data_ff  <= new_data_in;
         failed_ff    <= failed_in;
         busy_ff      <= busy_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.drive_enable = drive_en_ff;
   assign rsp_chan.drive_level  = drive_lvl_ff;
   assign rsp_chan.humidity     = hum_ff;
   assign rsp_chan.temperature  = temp_ff;
   assign rsp_chan.new_data     = new_data_ff;
   assign rsp_chan.read_failed  = failed_ff;
   assign rsp_chan.busy_res     = busy_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         release_ff      <= RELEASE_RST;
         start_low_ff    <= START_LOW_RST;
         start_high_ff   <= START_HIGH_RST;
         settle_ff       <= SETTLE_RST;
         min_interval_ff <= MIN_INTERVAL_RST;
         timeout_ff      <= TIMEOUT_RST;
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            REG_RELEASE:      release_ff      <= csr_pwdata[LONG_W-1:0];
            REG_START_LOW:    start_low_ff    <= csr_pwdata[LONG_W-1:0];
            REG_START_HIGH:   start_high_ff   <= csr_pwdata[SHORT_W-1:0];
            REG_SETTLE:       settle_ff       <= csr_pwdata[SHORT_W-1:0];
            REG_MIN_INTERVAL: min_interval_ff <= csr_pwdata[LONG_W-1:0];
            REG_TIMEOUT:      timeout_ff      <= csr_pwdata[SHORT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (csr_paddr[4:2])
         REG_RELEASE:      csr_prdata = CSR_DATA_W'(release_ff);
         REG_START_LOW:    csr_prdata = CSR_DATA_W'(start_low_ff);
         REG_START_HIGH:   csr_prdata = CSR_DATA_W'(start_high_ff);
         REG_SETTLE:       csr_prdata = CSR_DATA_W'(settle_ff);
         REG_MIN_INTERVAL: csr_prdata = CSR_DATA_W'(min_interval_ff);
         REG_TIMEOUT:      csr_prdata = CSR_DATA_W'(timeout_ff);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

FILE: rtl/swhsr_checker.sv
module swhsr_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic drive_enable,
   input logic drive_level,
   input logic new_data,
   input logic read_failed,
   input logic busy_res
);

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // Drive high only while driving
   a_drive_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && drive_level |-> drive_enable)
      else $error("drive level high without drive enable");

   // Drive only during a read
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && drive_enable |-> busy_res)
      else $error("line driven while idle");

   // End of read: one outcome, and back to idle
   a_read_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (new_data || read_failed) |-> !busy_res && !(new_data && read_failed))
      else $error("bad read completion");

   // No response word right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind single_wire_humidity_sensor_reader swhsr_checker u_swhsr_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .drive_enable (rsp_chan.drive_enable),
   .drive_level  (rsp_chan.drive_level),
   .new_data     (rsp_chan.new_data),
   .read_failed  (rsp_chan.read_failed),
   .busy_res     (rsp_chan.busy_res)
);

FILE: tb/single_wire_humidity_sensor_reader_tb.sv
module single_wire_humidity_sensor_reader_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import swhsr_pkg::*;

   localparam int          UNUSED_REG_INDEX = 6;
   localparam int          HOLD_CYCLES      = 200;
   localparam int unsigned CYCLE_LIMIT      = 2000000;
   localparam logic [PULSE_COUNT_WIDTH-1:0] COUNT_TOP = '1;

   typedef struct packed {
      logic             drive_enable;
      logic             drive_level;
      logic [BYTE_W-1:0] humidity;
      logic [BYTE_W-1:0] temperature;
      logic             new_data;
      logic             read_failed;
      logic             busy_res;
   } sensor_reading_type;

   // Tracks the reader's sequence per tick and holds the readings still owed
   class sensor_read_tracker;
      logic [LONG_W-1:0]  rel_len = RELEASE_RST;
      logic [LONG_W-1:0]  low_len = START_LOW_RST;
      logic [SHORT_W-1:0] high_len = START_HIGH_RST;
      logic [SHORT_W-1:0] settle_len = SETTLE_RST;
      logic [LONG_W-1:0]  min_gap = MIN_INTERVAL_RST;
      logic [SHORT_W-1:0] pulse_limit = TIMEOUT_RST;

      phase_type                    phase = PH_IDLE;
      logic [LONG_W-1:0]            phase_ticks = '0;
      logic [LONG_W-1:0]            since_read = '1;
      logic [PULSE_COUNT_WIDTH-1:0] low_count = '0;
      logic [PULSE_COUNT_WIDTH-1:0] high_count = '0;
      logic [5:0]                   bit_count = '0;
      logic [FRAME_BITS-1:0]        frame = '0;
      logic [BYTE_W-1:0]            humidity = '0;
      logic [BYTE_W-1:0]            temperature = '0;

      sensor_reading_type pending_readings[$];
      int                 errors = 0;

      function void set_reg(int unsigned idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_RELEASE:      rel_len = value[LONG_W-1:0];
            REG_START_LOW:    low_len = value[LONG_W-1:0];
            REG_START_HIGH:   high_len = value[SHORT_W-1:0];
            REG_SETTLE:       settle_len = value[SHORT_W-1:0];
            REG_MIN_INTERVAL: min_gap = value[LONG_W-1:0];
            REG_TIMEOUT:      pulse_limit = value[SHORT_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] reg_value(int unsigned idx);
         case (idx)
            REG_RELEASE:      return CSR_DATA_W'(rel_len);
            REG_START_LOW:    return CSR_DATA_W'(low_len);
            REG_START_HIGH:   return CSR_DATA_W'(high_len);
            REG_SETTLE:       return CSR_DATA_W'(settle_len);
            REG_MIN_INTERVAL: return CSR_DATA_W'(min_gap);
            REG_TIMEOUT:      return CSR_DATA_W'(pulse_limit);
            default:          return '0;
         endcase
      endfunction

      function logic [LONG_W-1:0] step_length(phase_type p);
         case (p)
            PH_RELEASE:    return rel_len;
            PH_START_LOW:  return low_len;
            PH_START_HIGH: return LONG_W'(high_len);
            default:       return LONG_W'(settle_len);
         endcase
      endfunction

      function int unsigned step_total();
         return int'(rel_len) + int'(low_len) + int'(high_len) + int'(settle_len);
      endfunction

      // Skip zero-length timed steps on entry
      function void enter_phase(phase_type p);
         phase_type q;
         q = p;
         while (q >= PH_RELEASE && q <= PH_SETTLE && step_length(q) == 0)
            q = phase_type'(q + 4'd1);
         phase = q;
         phase_ticks = '0;
         if (q == PH_RESP_LOW) low_count = '0;
      endfunction

      function logic [PULSE_COUNT_WIDTH-1:0] sat_inc(logic [PULSE_COUNT_WIDTH-1:0] c);
         return (c == COUNT_TOP) ? c : c + 1'b1;
      endfunction

      function bit pulse_over(logic [PULSE_COUNT_WIDTH-1:0] c);
         return (c > pulse_limit) || (c == COUNT_TOP);
      endfunction

      // Advance one line sample and queue the reading it produces
      function void take_tick(logic level, logic want);
         bit                 accept;
         logic               stored;
         logic               failed;
         logic [BYTE_W-1:0]  sum;
         sensor_reading_type r;
         stored = 1'b0;
         failed = 1'b0;
         accept = (phase == PH_IDLE) && want && (since_read >= min_gap);
         if (accept) since_read = '0;
         else if (since_read != '1) since_read = since_read + 1'b1;

         if (accept) begin
            bit_count = '0;
            frame = '0;
            low_count = '0;
            high_count = '0;
            enter_phase(PH_RELEASE);
         end else begin
            case (phase)
               PH_IDLE: ;
               PH_RELEASE, PH_START_LOW, PH_START_HIGH, PH_SETTLE: begin
                  phase_ticks = phase_ticks + 1'b1;
                  if (phase_ticks >= step_length(phase)) enter_phase(phase_type'(phase + 4'd1));
               end
               PH_RESP_LOW, PH_BIT_LOW: begin
                  if (!level) begin
                     low_count = sat_inc(low_count);
                     if (pulse_over(low_count)) begin
                        phase = PH_IDLE;
                        failed = 1'b1;
                     end
                  end else begin
                     phase = (phase == PH_RESP_LOW) ? PH_RESP_HIGH : PH_BIT_HIGH;
                     high_count = PULSE_COUNT_WIDTH'(1);
                  end
               end
               PH_RESP_HIGH, PH_BIT_HIGH: begin
                  if (level) begin
                     high_count = sat_inc(high_count);
                     if (pulse_over(high_count)) begin
                        phase = PH_IDLE;
                        failed = 1'b1;
                     end
                  end else if (phase == PH_RESP_HIGH) begin
                     phase = PH_BIT_LOW;
                     low_count = PULSE_COUNT_WIDTH'(1);
                  end else begin
                     frame = {frame[FRAME_BITS-2:0], high_count > low_count};
                     bit_count = bit_count + 1'b1;
                     if (bit_count >= FRAME_BITS) begin
                        sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
                        if (sum == frame[7:0]) begin
                           humidity = frame[39:32];
                           temperature = frame[23:16];
                           stored = 1'b1;
                        end else begin
                           failed = 1'b1;
                        end
                        phase = PH_IDLE;
                     end else begin
                        phase = PH_BIT_LOW;
                        low_count = PULSE_COUNT_WIDTH'(1);
                     end
                  end
               end
               default: phase = PH_IDLE;
            endcase
         end

         r.drive_enable = (phase == PH_START_LOW) || (phase == PH_START_HIGH);
         r.drive_level  = (phase == PH_START_HIGH);
         r.humidity     = humidity;
         r.temperature  = temperature;
         r.new_data     = stored;
         r.read_failed  = failed;
         r.busy_res     = (phase != PH_IDLE);
         pending_readings.push_back(r);
      endfunction

      // Compare one received word with the oldest owed reading
      function void match_reading(sensor_reading_type got);
         sensor_reading_type e;
         if (pending_readings.size() == 0) begin
            $error("unexpected result word: %h", got);
            errors++;
            return;
         end
         e = pending_readings.pop_front();
         if (got.drive_enable !== e.drive_enable) begin
            $error("drive_enable: expected %0d, got %0d", e.drive_enable, got.drive_enable);
            errors++;
         end
         if (got.drive_level !== e.drive_level) begin
            $error("drive_level: expected %0d, got %0d", e.drive_level, got.drive_level);
            errors++;
         end
         if (got.humidity !== e.humidity) begin
            $error("humidity: expected %0d, got %0d", e.humidity, got.humidity);
            errors++;
         end
         if (got.temperature !== e.temperature) begin
            $error("temperature: expected %0d, got %0d", e.temperature, got.temperature);
            errors++;
         end
         if (got.new_data !== e.new_data) begin
            $error("new_data: expected %0d, got %0d", e.new_data, got.new_data);
            errors++;
         end
         if (got.read_failed !== e.read_failed) begin
            $error("read_failed: expected %0d, got %0d", e.read_failed, got.read_failed);
            errors++;
         end
         if (got.busy_res !== e.busy_res) begin
            $error("busy_res: expected %0d, got %0d", e.busy_res, got.busy_res);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   swhsr_req_if req_if();
   swhsr_rsp_if rsp_if();

   sensor_read_tracker sb = new();

   bit          steady_flow = 1'b0;
   bit          squeeze_rsp = 1'b0;
   int unsigned cycle_count = 0;

   single_wire_humidity_sensor_reader uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         sb.match_reading({rsp_if.drive_enable, rsp_if.drive_level, rsp_if.humidity,
                           rsp_if.temperature, rsp_if.new_data, rsp_if.read_failed,
                           rsp_if.busy_res});
   end

   // Result side: random stalls, one long hold-off when asked
   initial begin
      int  held;
      bit  squeezed;
      held = 0;
      squeezed = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_rsp && !squeezed) begin
            rsp_if.ready <= 1'b0;
            held++;
            if (held >= HOLD_CYCLES) squeezed = 1'b1;
         end else if (steady_flow) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= 21);
         end
      end
   end

   // Offer one line sample and hold it until taken
   task automatic send_tick(input logic level, input logic want);
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < 21) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.line_level   <= level;
      req_if.read_request <= want;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.take_tick(level, want);
   endtask

   task automatic send_pulse(input logic level, input int n);
      repeat (n) send_tick(level, $urandom_range(7) == 0);
   endtask

   // Feed a released line until the sequence returns to idle
   task automatic flush_idle();
      while (sb.phase != PH_IDLE) send_tick(1'b1, 1'b0);
   endtask

   task automatic wait_ready();
      while (sb.since_read < sb.min_gap) send_tick(1'($urandom_range(1)), 1'b0);
   endtask

   // Request a read and cover the timed start steps
   task automatic start_read();
      int unsigned steps;
      steps = sb.step_total();
      send_tick(1'($urandom_range(1)), 1'b1);
      repeat (steps) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // Sensor answer: response pulses, then nbits of the frame MSB first
   task automatic send_frame(input logic [31:0] payload, input bit good, input int nbits);
      logic [BYTE_W-1:0]     chk;
      logic [FRAME_BITS-1:0] word;
      int                    lo;
      int                    hi;
      chk = payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0];
      if (!good) chk = chk ^ 8'($urandom_range(1, 255));
      word = {payload, chk};
      send_pulse(1'b0, $urandom_range(1, 4));
      send_pulse(1'b1, $urandom_range(1, 4));
      for (int i = FRAME_BITS - 1; i > FRAME_BITS - 1 - nbits; i--) begin
         lo = $urandom_range(1, 2);
         hi = word[i] ? lo + $urandom_range(1, 2) : $urandom_range(1, lo);
         send_pulse(1'b0, lo);
         send_pulse(1'b1, hi);
      end
      if (nbits == FRAME_BITS) send_pulse(1'b0, 1);
   endtask

   task automatic send_read(input logic [31:0] payload, input bit good, input int nbits);
      start_read();
      send_frame(payload, good, nbits);
   endtask

   // Stop offering words and let every owed result come out
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input int unsigned idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * idx);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_verify(input int unsigned idx);
      logic [CSR_DATA_W-1:0] want;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * idx);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      want = sb.reg_value(idx);
      if (csr_prdata !== want) begin
         $error("register %0d: expected %0d, got %0d", idx, want, csr_prdata);
         sb.errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Load all six registers while idle, then read them back
   task automatic load_regs(input logic [CSR_DATA_W-1:0] rel, input logic [CSR_DATA_W-1:0] lo,
                            input logic [CSR_DATA_W-1:0] hi, input logic [CSR_DATA_W-1:0] st,
                            input logic [CSR_DATA_W-1:0] gap,
                            input logic [CSR_DATA_W-1:0] limit);
      flush_idle();
      drain();
      csr_write(REG_RELEASE, rel);
      csr_write(REG_START_LOW, lo);
      csr_write(REG_START_HIGH, hi);
      csr_write(REG_SETTLE, st);
      csr_write(REG_MIN_INTERVAL, gap);
      csr_write(REG_TIMEOUT, limit);
      for (int i = REG_RELEASE; i <= REG_TIMEOUT; i++) csr_verify(i);
   endtask

   initial begin
      int pick;
      req_if.valid        <= 1'b0;
      req_if.line_level   <= 1'b1;
      req_if.read_request <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      do @(negedge clock); while (reset);

      // Saturated interval counter lets the first read through; upper bits dropped
      load_regs(32'hFF00_0002, 3, 32'hABCD_0001, 2, 32'h00FF_FFFF, 8);
      csr_write(UNUSED_REG_INDEX, '1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_read(32'hFF00_FF01, 1'b1, FRAME_BITS);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);

      // Zero-length steps, no minimum interval: bad checksum, pulse timeouts
      load_regs(0, 0, 0, 0, 0, 5);
      send_read(32'h1234_5678, 1'b0, FRAME_BITS);
      send_read($urandom(), 1'b1, 5);
      send_pulse(1'b0, 7);
      flush_idle();
      send_read($urandom(), 1'b1, 3);
      send_pulse(1'b1, 7);
      flush_idle();

      // Zero timeout fails on the first counted sample
      load_regs(1, 1, 1, 1, 0, 0);
      send_read($urandom(), 1'b1, 0);
      flush_idle();

      // Long low pulse runs out while the result side holds off
      load_regs(1, 1, 1, 1, 0, 40);
      squeeze_rsp = 1'b1;
      start_read();
      send_pulse(1'b0, 45);
      flush_idle();

      // Random settings: full reads, truncated reads, pulse timeouts and random ticks
      for (int ph = 0; ph < 2; ph++) begin
         load_regs($urandom_range(0, 3), $urandom_range(0, 4), $urandom_range(0, 3),
                   $urandom_range(0, 3), $urandom_range(0, 40), $urandom_range(4, 12));
         steady_flow = (ph == 0);
         for (int n = 0; n < 2; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
               if ($urandom_range(99) < 85) wait_ready();
               send_read($urandom(), $urandom_range(99) < 80, FRAME_BITS);
            end else if (pick < 65) begin
               send_read($urandom(), 1'b1, $urandom_range(0, FRAME_BITS - 1));
               repeat ($urandom_range(0, 10))
                  send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            end else if (pick < 85) begin
               send_read($urandom(), 1'b1, $urandom_range(0, 10));
               send_pulse(1'($urandom_range(1)), int'(sb.pulse_limit) + $urandom_range(1, 3));
            end else begin
               repeat ($urandom_range(5, 30))
                  send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            flush_idle();
            repeat ($urandom_range(0, 3)) send_tick(1'b1, 1'b0);
         end
      end
      steady_flow = 1'b0;

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/swhsr_pkg.sv
rtl/swhsr_req_if.sv
rtl/swhsr_rsp_if.sv
rtl/single_wire_humidity_sensor_reader.sv
rtl/swhsr_checker.sv
tb/single_wire_humidity_sensor_reader_tb.sv
